// ===== hdl/ntc_adc_to_temperature_macros.svh =====
// Assertion macros shared by the thermistor conversion block.
`ifndef NTC_ADC_TO_TEMPERATURE_MACROS_SVH
`define NTC_ADC_TO_TEMPERATURE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NTC_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NTC_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hdl/ntc_pkg.sv =====
// Types and constants shared by the thermistor conversion block.
package ntc_pkg;

  typedef enum logic [1:0] {
    ST_OK,
    ST_ZERO,
    ST_SUPPLY,
    ST_SAT
  } ntc_status_t;

  localparam logic [2:0] REG_SERIES   = 3'd0;
  localparam logic [2:0] REG_BETA     = 3'd1;
  localparam logic [2:0] REG_REF_TEMP = 3'd2;
  localparam logic [2:0] REG_SUPPLY   = 3'd3;
  localparam logic [2:0] REG_ADC_REF  = 3'd4;

  localparam logic [13:0] BETA_RESET    = 14'd3950;
  localparam logic [14:0] REF_RESET     = 15'd2500;
  localparam logic [12:0] SUPPLY_RESET  = 13'd5000;
  localparam logic [12:0] ADC_REF_RESET = 13'd3300;

  localparam int INV_W = 34;
  localparam int T4_Q_W = 24;
  localparam int LOG_FRAC_BITS = 16;

  localparam logic signed [15:0] TEMP_MAX = 16'sd30000;
  localparam logic signed [15:0] TEMP_MIN = -16'sd27315;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [29:0] T4_REM = 30'd655360000;
  localparam logic signed [24:0] KELVIN_1E4 = 25'sd2731500;
  localparam logic [30:0] DIV100_MUL = 31'd1374389535;
  localparam logic [17:0] CENTI_MAX = 18'd30000;
  localparam logic [17:0] CENTI_MIN_MAG = 18'd27315;

  typedef struct packed {
    logic        done;
    ntc_status_t status;
  } ntc_flag_t;

  typedef struct packed {
    ntc_flag_t flag;
    logic      neg;
  } ntc_lnside_t;

  typedef struct packed {
    logic [13:0]      beta;
    logic [12:0]      supply;
    logic [12:0]      adc_ref;
    logic [INV_W-1:0] inv;
    logic             busy;
  } ntc_cfg_t;

endpackage

// ===== hdl/ntc_cfg.sv =====
// Configuration registers and the sequential reciprocal of the reference temperature.
`include "ntc_adc_to_temperature_macros.svh"

module ntc_cfg import ntc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [19:0] cfg_data,
  output ntc_cfg_t    cfg
);

  localparam logic [46:0] INV_DIVIDEND = {7'd100, 40'd0};
  localparam logic [5:0] INV_STEPS = 6'd47;

  logic [13:0] beta;
  logic [14:0] ref_temp;
  logic [12:0] supply;
  logic [12:0] adc_ref;
  logic [5:0]  cnt;
  logic [15:0] rem;
  logic [46:0] quo;
  logic [15:0] t0c;
  logic [16:0] trial;

  assign cfg_ready = 1'b1;
  assign t0c = 16'($signed({{2{ref_temp[14]}}, ref_temp}) + 17'sd27315);
  assign trial = {rem, quo[46]};

  always_ff @(posedge clk) begin
    if (rst) begin
      beta <= BETA_RESET;
      ref_temp <= REF_RESET;
      supply <= SUPPLY_RESET;
      adc_ref <= ADC_REF_RESET;
      cnt <= INV_STEPS;
      rem <= '0;
      quo <= INV_DIVIDEND;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index == REG_REF_TEMP) begin
        cnt <= INV_STEPS;
        rem <= '0;
        quo <= INV_DIVIDEND;
      end else if (cnt != 6'd0) begin
        if (trial >= {1'b0, t0c}) begin
          rem <= 16'(trial - {1'b0, t0c});
          quo <= {quo[45:0], 1'b1};
        end else begin
          rem <= trial[15:0];
          quo <= {quo[45:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SERIES: begin
          end
          REG_BETA: beta <= cfg_data[13:0];
          REG_REF_TEMP: ref_temp <= cfg_data[14:0];
          REG_SUPPLY: supply <= cfg_data[12:0];
          REG_ADC_REF: adc_ref <= cfg_data[12:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    cfg.beta = (beta == 14'd0) ? 14'd1 : beta;
    cfg.supply = supply;
    cfg.adc_ref = adc_ref;
    cfg.inv = quo[INV_W-1:0];
    cfg.busy = (cnt != 6'd0);
  end

  `NTC_ASSERT_NXT(a_ref_write_busy, cfg_valid && cfg_ready && cfg_index == REG_REF_TEMP, cfg.busy, "reference write did not start the reciprocal")

endmodule

// ===== hdl/ntc_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
module ntc_div_pipe import ntc_pkg::*; #(
  parameter int NW = 45,
  parameter int DW = 29,
  parameter int SW = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_rem,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic          sv [NW];
  logic [NW-1:0] sq [NW];
  logic [DW-1:0] sr [NW];
  logic [DW-1:0] sd [NW];
  logic [SW-1:0] ss [NW];
  logic [DW+NW-1:0] step_next [NW];

  function automatic logic [DW+NW-1:0] div_step(input logic [DW-1:0] rem,
                                                input logic [NW-1:0] num,
                                                input logic [DW-1:0] den);
    logic [DW:0]   trial;
    logic [DW-1:0] rem_next;
    logic          qbit;
    trial = {rem, num[NW-1]};
    if (trial >= {1'b0, den}) begin
      rem_next = DW'(trial - {1'b0, den});
      qbit = 1'b1;
    end else begin
      rem_next = trial[DW-1:0];
      qbit = 1'b0;
    end
    return {rem_next, num[NW-2:0], qbit};
  endfunction

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        step_next[k] = div_step(in_rem, in_num, in_den);
      end else begin
        step_next[k] = div_step(sr[k-1], sq[k-1], sd[k-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NW; k++) begin
      if (rst) begin
        sv[k] <= 1'b0;
      end else if (k == 0) begin
        sv[k] <= in_valid;
      end else begin
        sv[k] <= sv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NW; k++) begin
      sr[k] <= step_next[k][DW+NW-1:NW];
      sq[k] <= step_next[k][NW-1:0];
      if (k == 0) begin
        sd[k] <= in_den;
        ss[k] <= in_side;
      end else begin
        sd[k] <= sd[k-1];
        ss[k] <= ss[k-1];
      end
    end
  end

  assign out_valid = sv[NW-1];
  assign out_quo = sq[NW-1];
  assign out_side = ss[NW-1];

endmodule

// ===== hdl/ntc_log2_pipe.sv =====
// Pipelined base-2 logarithm: leading one, normalize, then one squaring per stage.
module ntc_log2_pipe import ntc_pkg::*; #(
  parameter int XW = 45,
  parameter int EW = $clog2(XW),
  parameter int SW = 3
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [XW-1:0]            in_x,
  input  logic [SW-1:0]            in_side,
  output logic                     out_valid,
  output logic [EW-1:0]            out_e,
  output logic [LOG_FRAC_BITS-1:0] out_frac,
  output logic [SW-1:0]            out_side
);

  localparam int NS = LOG_FRAC_BITS;
  localparam logic [EW-1:0] NORM_POS = EW'(30);

  logic          va;
  logic [XW-1:0] xa;
  logic [EW-1:0] ea;
  logic [SW-1:0] sa;
  logic          vb;
  logic [30:0]   mb;
  logic [EW-1:0] eb;
  logic [SW-1:0] sb;

  logic [XW-1:0]    x_fix;
  logic [EW-1:0]    e_find;
  logic [XW-1:0]    right_sh;
  logic [XW+30:0]   left_sh;
  logic [30:0]      m_norm;

  logic          qv [NS];
  logic [30:0]   qm [NS];
  logic [NS-1:0] qf [NS];
  logic [EW-1:0] qe [NS];
  logic [SW-1:0] qs [NS];
  logic [31:0]   sq_next [NS];

  function automatic logic [31:0] sq_step(input logic [30:0] m);
    logic [61:0] p;
    logic [31:0] t;
    p = 62'(m) * 62'(m);
    t = p[61:30];
    if (t[31]) begin
      return {t[31:1], 1'b1};
    end else begin
      return {t[30:0], 1'b0};
    end
  endfunction

  always_comb begin
    x_fix = (in_x == '0) ? XW'(1) : in_x;
    e_find = '0;
    for (int i = 0; i < XW; i++) begin
      if (x_fix[i]) begin
        e_find = EW'(i);
      end
    end
  end

  always_comb begin
    right_sh = xa >> (ea - NORM_POS);
    left_sh = (XW+31)'(xa) << (NORM_POS - ea);
    m_norm = (ea >= NORM_POS) ? right_sh[30:0] : left_sh[30:0];
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        sq_next[k] = sq_step(mb);
      end else begin
        sq_next[k] = sq_step(qm[k-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      for (int k = 0; k < NS; k++) begin
        qv[k] <= 1'b0;
      end
    end else begin
      va <= in_valid;
      vb <= va;
      for (int k = 0; k < NS; k++) begin
        qv[k] <= (k == 0) ? vb : qv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    xa <= x_fix;
    ea <= e_find;
    sa <= in_side;
    mb <= m_norm;
    eb <= ea;
    sb <= sa;
    for (int k = 0; k < NS; k++) begin
      qm[k] <= sq_next[k][31:1];
      if (k == 0) begin
        qf[k] <= {{(NS-1){1'b0}}, sq_next[k][0]};
        qe[k] <= eb;
        qs[k] <= sb;
      end else begin
        qf[k] <= {qf[k-1][NS-2:0], sq_next[k][0]};
        qe[k] <= qe[k-1];
        qs[k] <= qs[k-1];
      end
    end
  end

  assign out_valid = qv[NS-1];
  assign out_e = qe[NS-1];
  assign out_frac = qf[NS-1];
  assign out_side = qs[NS-1];

endmodule

// ===== hdl/ntc_adc_to_temperature.sv =====
// Top level: NTC divider sample to temperature by the Beta equation, fully pipelined.
// Throughput: one word per cycle while busy is low; the three dividers retire one quotient bit per stage.
// The receiver cannot stall; done is high for one cycle per word.
// Reset, and every write of ref_temp_centi_c, runs the sequential reciprocal with busy high.
// Reset loads the register defaults and empties the pipeline.
`include "ntc_adc_to_temperature_macros.svh"

module ntc_adc_to_temperature import ntc_pkg::*; #(
  parameter int ADC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        adc_code,
  output logic               done,
  output logic signed [15:0] temp_centi_c,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);

  localparam int NUM_W = ADC_BITS + 13;
  localparam int RATIO_W = NUM_W + 16;
  localparam int EW = $clog2(RATIO_W);
  localparam int MAG_W = EW + 16;
  localparam int LNQ_W = MAG_W + 24;
  localparam int S_W = LNQ_W + 2;
  localparam int SD_W = S_W - 1;
  localparam int FLAG_W = $bits(ntc_flag_t);
  localparam int LNS_W = $bits(ntc_lnside_t);
  localparam logic [NUM_W-1:0] FULL = NUM_W'((64'd1 << ADC_BITS) - 64'd1);
  localparam logic signed [EW+16:0] LOG_BIAS = (EW+17)'(1 << 20);
  localparam logic signed [S_W-1:0] S_MIN = S_W'(T4_REM);

  ntc_cfg_t cfg;
  logic     accept;

  logic             v1;
  logic [NUM_W-1:0] num1;
  logic [NUM_W-1:0] top1;

  logic               v2;
  ntc_flag_t          flag2;
  logic [NUM_W-1:0]   den2;
  logic [RATIO_W-1:0] dvd2;
  ntc_flag_t          flag2_next;

  logic               ratio_v;
  logic [RATIO_W-1:0] ratio_q;
  logic [FLAG_W-1:0]  ratio_side;

  logic                     log_v;
  logic [EW-1:0]            log_e;
  logic [LOG_FRAC_BITS-1:0] log_frac;
  logic [FLAG_W-1:0]        log_side;

  logic               v3;
  ntc_flag_t          flag3;
  logic               neg3;
  logic [MAG_W-1:0]   mag3;
  logic signed [EW+16:0] lval;

  logic             v4;
  ntc_flag_t        flag4;
  logic             neg4;
  logic [MAG_W-1:0] lnmag4;
  logic [MAG_W+31:0] ln_prod;
  ntc_lnside_t      lnside4;

  logic             beta_v;
  logic [LNQ_W-1:0] beta_q;
  logic [LNS_W-1:0] beta_side;
  ntc_lnside_t      beta_sd;

  logic                  v5;
  ntc_flag_t             flag5;
  logic [SD_W-1:0]       s5;
  logic signed [S_W-1:0] s_sum;
  ntc_flag_t             flag5_next;

  logic              t4_v;
  logic [T4_Q_W-1:0] t4_q;
  logic [FLAG_W-1:0] t4_side;

  logic               v6;
  ntc_flag_t          flag6;
  logic               neg6;
  logic [23:0]        abs6;
  logic signed [24:0] diff;

  logic        v7;
  ntc_flag_t   flag7;
  logic        neg7;
  logic [54:0] prod7;

  logic [17:0]        q8;
  logic signed [15:0] temp_next;
  ntc_status_t        status_next;
  ntc_status_t        status_reg;

  ntc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign busy = cfg.busy;
  assign accept = start && !busy;

  always_comb begin
    flag2_next.done = 1'b0;
    flag2_next.status = ST_OK;
    if (num1 == '0) begin
      flag2_next.done = 1'b1;
      flag2_next.status = ST_ZERO;
    end else if (num1 >= top1) begin
      flag2_next.done = 1'b1;
      flag2_next.status = ST_SUPPLY;
    end
  end

  ntc_div_pipe #(.NW(RATIO_W), .DW(NUM_W), .SW(FLAG_W)) u_ratio_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_num    (dvd2),
    .in_rem    ({NUM_W{1'b0}}),
    .in_den    (den2),
    .in_side   (flag2),
    .out_valid (ratio_v),
    .out_quo   (ratio_q),
    .out_side  (ratio_side)
  );

  ntc_log2_pipe #(.XW(RATIO_W), .EW(EW), .SW(FLAG_W)) u_log2 (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ratio_v),
    .in_x      (ratio_q),
    .in_side   (ratio_side),
    .out_valid (log_v),
    .out_e     (log_e),
    .out_frac  (log_frac),
    .out_side  (log_side)
  );

  assign lval = $signed({1'b0, log_e, log_frac}) - LOG_BIAS;
  assign ln_prod = (MAG_W+32)'(mag3) * (MAG_W+32)'(LN2_Q32);

  always_comb begin
    lnside4.flag = flag4;
    lnside4.neg = neg4;
  end

  ntc_div_pipe #(.NW(LNQ_W), .DW(14), .SW(LNS_W)) u_beta_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_num    ({lnmag4, 24'd0}),
    .in_rem    (14'd0),
    .in_den    (cfg.beta),
    .in_side   (lnside4),
    .out_valid (beta_v),
    .out_quo   (beta_q),
    .out_side  (beta_side)
  );

  assign beta_sd = ntc_lnside_t'(beta_side);

  always_comb begin
    if (beta_sd.neg) begin
      s_sum = $signed(S_W'(cfg.inv)) - $signed(S_W'(beta_q));
    end else begin
      s_sum = $signed(S_W'(cfg.inv)) + $signed(S_W'(beta_q));
    end
    flag5_next = beta_sd.flag;
    if (!beta_sd.flag.done && s_sum <= S_MIN) begin
      flag5_next.done = 1'b1;
      flag5_next.status = ST_SAT;
    end
  end

  ntc_div_pipe #(.NW(T4_Q_W), .DW(SD_W), .SW(FLAG_W)) u_t4_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_num    ({T4_Q_W{1'b0}}),
    .in_rem    (SD_W'(T4_REM)),
    .in_den    (s5),
    .in_side   (flag5),
    .out_valid (t4_v),
    .out_quo   (t4_q),
    .out_side  (t4_side)
  );

  assign diff = $signed({1'b0, t4_q}) - KELVIN_1E4;

  always_comb begin
    q8 = prod7[54:37];
    temp_next = TEMP_MIN;
    status_next = ST_OK;
    if (flag7.done) begin
      status_next = flag7.status;
      temp_next = (flag7.status == ST_SAT) ? TEMP_MAX : TEMP_MIN;
    end else if (neg7) begin
      if (q8 > CENTI_MIN_MAG) begin
        temp_next = TEMP_MIN;
        status_next = ST_SAT;
      end else begin
        temp_next = -$signed(16'(q8));
      end
    end else begin
      if (q8 > CENTI_MAX) begin
        temp_next = TEMP_MAX;
        status_next = ST_SAT;
      end else begin
        temp_next = $signed(16'(q8));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= log_v;
      v4 <= v3;
      v5 <= beta_v;
      v6 <= t4_v;
      v7 <= v6;
      done <= v7;
    end
  end

  always_ff @(posedge clk) begin
    num1 <= NUM_W'(adc_code[ADC_BITS-1:0]) * NUM_W'(cfg.adc_ref);
    top1 <= NUM_W'(cfg.supply) * FULL;
    flag2 <= flag2_next;
    den2 <= top1 - num1;
    dvd2 <= {num1, 16'd0};
    flag3 <= ntc_flag_t'(log_side);
    neg3 <= lval[EW+16];
    mag3 <= lval[EW+16] ? MAG_W'(-lval) : MAG_W'(lval);
    flag4 <= flag3;
    neg4 <= neg3;
    lnmag4 <= ln_prod[MAG_W+31:32];
    flag5 <= flag5_next;
    s5 <= s_sum[SD_W-1:0];
    flag6 <= ntc_flag_t'(t4_side);
    neg6 <= diff[24];
    abs6 <= diff[24] ? 24'(-diff) : diff[23:0];
    flag7 <= flag6;
    neg7 <= neg6;
    prod7 <= 55'(abs6) * 55'(DIV100_MUL);
    temp_centi_c <= temp_next;
    status_reg <= status_next;
  end

  assign status = status_reg;

  `NTC_ASSERT_IMP(a_cold_code, done && (status == ST_ZERO || status == ST_SUPPLY), temp_centi_c == TEMP_MIN, "cold status without minimum temperature")
  `NTC_ASSERT_IMP(a_sat_end, done && status == ST_SAT, temp_centi_c == TEMP_MAX || temp_centi_c == TEMP_MIN, "saturated status off the range ends")
  `NTC_ASSERT_IMP(a_ok_range, done && status == ST_OK, temp_centi_c >= TEMP_MIN && temp_centi_c <= TEMP_MAX, "valid result outside range")

endmodule
